// File: hdl/tcbr_pkg.sv
package tcbr_pkg;

    localparam int FONT_DEPTH   = 4096;
    localparam int FONT_ADDR_W  = 12;
    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 15;
    localparam int STEP_W       = 4;
    localparam int STEP_LAST    = 15;
    localparam int NUM_ATTRS    = 10;

    localparam int TEXT_ROWS_DEF = 25;
    localparam int TEXT_COLS_DEF = 80;

    // Byte steps between output bytes: mono scanline stride, plane step and colour scanline advance.
    localparam logic [OFFSET_W-1:0] MONO_LINE      = 15'd80;
    localparam logic [OFFSET_W-1:0] PLANE_STEP     = 15'd2;
    localparam logic [OFFSET_W-1:0] COLOUR_ROW_ADV = 15'd158;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Background in the high nibble, foreground in the low nibble.
    function automatic logic [7:0] colour_of_attr(input logic [3:0] at);
        logic [7:0] c;
        unique case (at)
            4'd0:    c = 8'h01;
            4'd1:    c = 8'h01;
            4'd2:    c = 8'h02;
            4'd3:    c = 8'h10;
            4'd4:    c = 8'h12;
            4'd5:    c = 8'h30;
            4'd6:    c = 8'h13;
            4'd7:    c = 8'h03;
            4'd8:    c = 8'h10;
            4'd9:    c = 8'h03;
            default: c = 8'h01;
        endcase
        return c;
    endfunction

    function automatic logic mono_reverse(input logic [3:0] at);
        logic m;
        unique case (at)
            4'd3, 4'd4, 4'd6, 4'd8: m = 1'b1;
            default:                m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/tcbr_ram.sv
module tcbr_ram
    import tcbr_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = FONT_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/text_cell_bitplane_renderer.sv
// Channel   | Handshake                  | Word
// ----------+----------------------------+---------------------------------------------
// input     | i_in_valid / o_in_stall    | action, font_index, font_byte, cell fields
// output    | o_out_valid / i_out_stall  | byte_offset, pixel_byte, last
// config    | i_cfg_we                   | mono_mode
//
// A load word writes the font RAM. A draw word gives 16 output words, one per cycle
// unless an output stall holds the pipeline, and it holds the font RAM read port for
// its 16 glyph reads; the next draw is taken while the last glyph read of the previous
// one is issued. A load is taken only when no glyph read is pending. Read data pass
// the RAM register, then the output register. Reset is synchronous; the font RAM is
// not cleared. An output stall freezes the pipeline, the RAM holds its read data.
module text_cell_bitplane_renderer
    import tcbr_pkg::*;
#(
    parameter int TEXT_ROWS = TEXT_ROWS_DEF,
    parameter int TEXT_COLS = TEXT_COLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [FONT_ADDR_W-1:0] i_font_index,
    input  logic [BYTE_W-1:0]      i_font_byte,
    input  logic [6:0]             i_column,
    input  logic [4:0]             i_text_row,
    input  logic [7:0]             i_char_code,
    input  logic [3:0]             i_attr,
    input  logic                   i_inverted,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [OFFSET_W-1:0]    o_byte_offset,
    output logic [BYTE_W-1:0]      o_pixel_byte,
    output logic                   o_last
);

    logic r_mono_mode;

    t_seq_state r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [7:0]          r_ch;
    logic                r_mode;
    logic [OFFSET_W-1:0] r_off;
    logic                r_a0, r_b0, r_a1, r_b1;

    logic                r_s1_valid;
    logic [OFFSET_W-1:0] r_s1_off;
    logic                r_s1_a, r_s1_b, r_s1_last;

    logic                r_out_valid;
    logic [OFFSET_W-1:0] r_out_off;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic                   s1_move, issue, last_issue, accept, load_we, draw_go;
    logic                   in_range, plane;
    logic [3:0]             at_eff, fg, bg;
    logic [7:0]             colour;
    logic                   mono_m;
    logic [OFFSET_W-1:0]    row_base, start_off, off_step;
    logic [FONT_ADDR_W-1:0] rd_addr;
    logic [3:0]             glyph_row;
    logic [BYTE_W-1:0]      glyph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mono_mode <= i_cfg_data;
        end
    end

    // Pipeline flow: issue stage -> RAM read / stage 1 -> output register.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign issue      = (r_state == SEQ_RUN) && (!r_s1_valid || s1_move);
    assign last_issue = issue && (r_step == STEP_W'(STEP_LAST));

    assign o_in_stall = (r_state == SEQ_RUN) && !(last_issue && (i_action == ACTION_DRAW));
    assign accept     = i_in_valid && !o_in_stall;
    assign load_we    = accept && (i_action == ACTION_LOAD);

    assign in_range = (int'(i_column) < TEXT_COLS) && (int'(i_text_row) < TEXT_ROWS);
    assign draw_go  = accept && (i_action == ACTION_DRAW) && in_range;

    // Attribute decode for the incoming cell.
    always_comb begin
        at_eff = (int'(i_attr) < NUM_ATTRS) ? i_attr : 4'd0;
        colour = colour_of_attr(at_eff);
        if (i_inverted) begin
            fg = colour[7:4];
            bg = colour[3:0];
        end else begin
            fg = colour[3:0];
            bg = colour[7:4];
        end
        mono_m   = mono_reverse(at_eff) ^ i_inverted;
        row_base = {i_text_row, 10'd0} + {2'd0, i_text_row, 8'd0};
        if (r_mono_mode) begin
            start_off = row_base + {8'd0, i_column};
        end else begin
            start_off = row_base + {7'd0, i_column[6:1], 2'b00} + {14'd0, i_column[0]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        if (draw_go) begin
            n_state = SEQ_RUN;
            n_step  = '0;
        end else if (last_issue) begin
            n_state = SEQ_IDLE;
            n_step  = '0;
        end else if (issue) begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // In mono mode every step uses plane 0 masks, which hold all-ones and the reverse-video flag.
    assign plane     = r_mode ? 1'b0 : r_step[0];
    assign glyph_row = r_mode ? r_step : {1'b0, r_step[3:1]};
    assign rd_addr   = {r_ch, glyph_row};
    assign off_step  = r_mode ? MONO_LINE : (r_step[0] ? COLOUR_ROW_ADV : PLANE_STEP);

    always_ff @(posedge i_clk) begin
        if (draw_go) begin
            r_ch   <= i_char_code;
            r_mode <= r_mono_mode;
            r_off  <= start_off;
            if (r_mono_mode) begin
                r_a0 <= 1'b1;
                r_a1 <= 1'b1;
                r_b0 <= mono_m;
                r_b1 <= mono_m;
            end else begin
                r_a0 <= fg[0] ^ bg[0];
                r_a1 <= fg[1] ^ bg[1];
                r_b0 <= bg[0];
                r_b1 <= bg[1];
            end
        end else if (issue) begin
            r_off <= r_off + off_step;
        end
    end

    tcbr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_font_index),
        .i_wdata (i_font_byte),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .o_rdata (glyph)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (issue) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_off  <= r_off;
            r_s1_a    <= plane ? r_a1 : r_a0;
            r_s1_b    <= plane ? r_b1 : r_b0;
            r_s1_last <= (r_step == STEP_W'(STEP_LAST));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_off  <= r_s1_off;
            r_out_byte <= (glyph & {BYTE_W{r_s1_a}}) ^ {BYTE_W{r_s1_b}};
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_offset = r_out_off;
    assign o_pixel_byte  = r_out_byte;
    assign o_last        = r_out_last;

endmodule
